// ===== rtl/core/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the reflection probe selector: request and
// response payloads, table entry layout, command, status and sequencer codes
// ----------------------------------------------------------------------------
package rps_pkg;

	localparam int unsigned MAX_PROBES_DEF = 16;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned EIDX_W   = 4;
	localparam int unsigned RIDX_W   = 4;
	localparam int unsigned DIFF_W   = COORD_W + 1;
	localparam int unsigned SQ_W     = 2 * COORD_W;
	localparam int unsigned DIST_W   = SQ_W + 2;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NOP    = 2'd3
	} rps_cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_BAD_INDEX = 2'd2,
		STATUS_EMPTY     = 2'd3
	} rps_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_QUERY,
		ST_RESP
	} rps_state_t;

	typedef struct packed {
		rps_cmd_t                  cmd;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] box_lo_x;
		logic signed [COORD_W-1:0] box_lo_y;
		logic signed [COORD_W-1:0] box_lo_z;
		logic signed [COORD_W-1:0] box_hi_x;
		logic signed [COORD_W-1:0] box_hi_y;
		logic signed [COORD_W-1:0] box_hi_z;
		logic [EIDX_W-1:0]         entry_index;
	} rps_req_t;

	typedef struct packed {
		rps_status_t       status;
		logic [RIDX_W-1:0] result_index;
		logic              inside_box;
	} rps_resp_t;

	// one table entry: centre and box offsets
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
	} rps_entry_t;

endpackage

// ===== rtl/core/rps_ram.sv =====
// ----------------------------------------------------------------------------
// rps_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module rps_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/reflection_probe_selector_unit.sv =====
// ----------------------------------------------------------------------------
// reflection_probe_selector_unit
// ordered probe table with add, remove and nearest contained probe query
// ----------------------------------------------------------------------------
// usage
//   requests come in on req / req_valid / req_stall, responses leave on
//   resp / resp_valid / resp_stall; every request gives exactly one response
//   req_stall is high whenever the sequencer is not idle, one request at a time
//   add, unused command, bad remove index and query on an empty table:
//     the sequencer goes straight to ST_RESP, then the response register loads
//   remove of entry k from n entries: the table ram is walked once from
//     entry k + 1 to entry n - 1, one entry shifted down per cycle
//   query on n entries: one entry is read per cycle from the single table
//     ram read port and flows through a four stage distance and
//     containment pipeline
//   the next request can be taken in the same cycle as the response turns
//   valid; a finished response sits in the output register while a new
//   request is taken, and the sequencer holds its next response until the
//   receiver drops resp_stall
//   reset empties the table (count to zero); entry storage is not cleared,
//   only entries below the count are ever read
// ----------------------------------------------------------------------------
module reflection_probe_selector_unit
	import rps_pkg::*;
#(
	parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  rps_req_t  req,
	output logic      resp_valid,
	input  logic      resp_stall,
	output rps_resp_t resp
);

	localparam int unsigned IDX_W   = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
	localparam int unsigned CNT_W   = $clog2(MAX_PROBES + 1);
	localparam int unsigned CMP_W   = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;
	localparam int unsigned ENTRY_W = $bits(rps_entry_t);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROBES);

	// sequencer and table state
	rps_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;

	// query point
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;

	// ram read stage
	logic              rd_v_s0;
	logic [IDX_W-1:0]  rd_idx_s0;
	logic [ENTRY_W-1:0] ram_rdata;
	rps_entry_t        ent_s0;

	// distance pipeline
	logic                     v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3;
	logic                     in_s1, in_s2, in_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [DIST_W-1:0]        dist_s3;

	// running best
	logic              found_q;
	logic [DIST_W-1:0] best_all_q, best_in_q;
	logic [IDX_W-1:0]  idx_all_q, idx_in_q;

	// pending and output response
	rps_resp_t res_q;
	logic      resp_valid_q;
	rps_resp_t resp_q;

	// control
	logic              accept;
	logic              issue;
	logic              full;
	logic              index_ok;
	logic              remove_done;
	logic              query_done;
	logic              out_free;
	logic              add_wr;
	logic              rm_wr;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	rps_entry_t        add_ent;

	// combinational stage results
	logic signed [DIFF_W-1:0]   dx_c, dy_c, dz_c;
	logic                       in_c;
	logic signed [2*DIFF_W-1:0] px2_c, py2_c, pz2_c;
	logic [DIST_W-1:0]          dist_c;

	function automatic logic axis_in(
		input logic signed [DIFF_W-1:0]  d,
		input logic signed [COORD_W-1:0] lo,
		input logic signed [COORD_W-1:0] hi
	);
		logic signed [DIFF_W-1:0] lo_e;
		logic signed [DIFF_W-1:0] hi_e;
		lo_e = $signed({lo[COORD_W-1], lo});
		hi_e = $signed({hi[COORD_W-1], hi});
		return !(d < lo_e) && !(d > hi_e);
	endfunction

	// table ram: add writes at the count, remove writes each entry one place down
	rps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PROBES)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr   (ptr_q[IDX_W-1:0]),
		.rdata_q (ram_rdata)
	);

	assign ent_s0 = rps_entry_t'(ram_rdata);

	// control outputs of the sequencer
	always_comb begin
		req_stall   = (state_q != ST_IDLE);
		accept      = req_valid && !req_stall;
		full        = (count_q == MAX_CNT);
		index_ok    = (CMP_W'(req.entry_index) < CMP_W'(count_q));
		issue       = ((state_q == ST_REMOVE) || (state_q == ST_QUERY)) && (ptr_q < count_q);
		remove_done = (state_q == ST_REMOVE) && !issue && !rd_v_s0;
		query_done  = (state_q == ST_QUERY) && !issue && !rd_v_s0 && !v_s1 && !v_s2 && !v_s3;
		out_free    = !resp_valid_q || !resp_stall;

		add_wr = accept && (req.cmd == CMD_ADD) && !full;
		rm_wr  = (state_q == ST_REMOVE) && rd_v_s0;

		add_ent.cx   = req.pos_x;
		add_ent.cy   = req.pos_y;
		add_ent.cz   = req.pos_z;
		add_ent.lo_x = req.box_lo_x;
		add_ent.lo_y = req.box_lo_y;
		add_ent.lo_z = req.box_lo_z;
		add_ent.hi_x = req.box_hi_x;
		add_ent.hi_y = req.box_hi_y;
		add_ent.hi_z = req.box_hi_z;

		ram_we = add_wr || rm_wr;
		if (rm_wr) begin
			ram_waddr = rd_idx_s0 - IDX_W'(1);
			ram_wdata = ram_rdata;
		end else begin
			ram_waddr = count_q[IDX_W-1:0];
			ram_wdata = ENTRY_W'(add_ent);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.cmd)
						CMD_REMOVE: state_d = index_ok ? ST_REMOVE : ST_RESP;
						CMD_QUERY:  state_d = (count_q != '0) ? ST_QUERY : ST_RESP;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_REMOVE: begin
				if (remove_done) begin
					state_d = ST_RESP;
				end
			end
			ST_QUERY: begin
				if (query_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// distance and containment datapath
	always_comb begin
		dx_c = $signed({px_q[COORD_W-1], px_q}) - $signed({ent_s0.cx[COORD_W-1], ent_s0.cx});
		dy_c = $signed({py_q[COORD_W-1], py_q}) - $signed({ent_s0.cy[COORD_W-1], ent_s0.cy});
		dz_c = $signed({pz_q[COORD_W-1], pz_q}) - $signed({ent_s0.cz[COORD_W-1], ent_s0.cz});
		in_c = axis_in(dx_c, ent_s0.lo_x, ent_s0.hi_x)
			&& axis_in(dy_c, ent_s0.lo_y, ent_s0.hi_y)
			&& axis_in(dz_c, ent_s0.lo_z, ent_s0.hi_z);

		// a square of a 17 bit difference always fits 32 bits
		px2_c = dx_s1 * dx_s1;
		py2_c = dy_s1 * dy_s1;
		pz2_c = dz_s1 * dz_s1;

		dist_c = DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			rd_v_s0      <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			found_q      <= 1'b0;
			resp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s0 <= issue;
			v_s1    <= rd_v_s0 && (state_q == ST_QUERY);
			v_s2    <= v_s1;
			v_s3    <= v_s2;

			// table count
			if (add_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (remove_done) begin
				count_q <= count_q - CNT_W'(1);
			end

			// walk pointer: remove starts just above the deleted entry
			if (accept) begin
				if (req.cmd == CMD_REMOVE) begin
					ptr_q <= CNT_W'(CMP_W'(req.entry_index) + CMP_W'(1));
				end else begin
					ptr_q <= '0;
				end
			end else if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end

			// contained probe seen in this query
			if (accept) begin
				found_q <= 1'b0;
			end else if (v_s3 && in_s3) begin
				found_q <= 1'b1;
			end

			// output register
			if ((state_q == ST_RESP) && out_free) begin
				resp_valid_q <= 1'b1;
			end else if (resp_valid_q && !resp_stall) begin
				resp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= req.pos_x;
			py_q <= req.pos_y;
			pz_q <= req.pos_z;
		end

		rd_idx_s0 <= ptr_q[IDX_W-1:0];

		dx_s1  <= dx_c;
		dy_s1  <= dy_c;
		dz_s1  <= dz_c;
		in_s1  <= in_c;
		idx_s1 <= rd_idx_s0;

		sqx_s2 <= px2_c[SQ_W-1:0];
		sqy_s2 <= py2_c[SQ_W-1:0];
		sqz_s2 <= pz2_c[SQ_W-1:0];
		in_s2  <= in_s1;
		idx_s2 <= idx_s1;

		dist_s3 <= dist_c;
		in_s3   <= in_s2;
		idx_s3  <= idx_s2;

		// nearest overall, first entry seeds it, strict compare keeps earliest
		if (v_s3 && ((idx_s3 == '0) || (dist_s3 < best_all_q))) begin
			best_all_q <= dist_s3;
			idx_all_q  <= idx_s3;
		end
		// nearest among the containing boxes
		if (v_s3 && in_s3 && (!found_q || (dist_s3 < best_in_q))) begin
			best_in_q <= dist_s3;
			idx_in_q  <= idx_s3;
		end

		// pending response
		if (accept) begin
			res_q.result_index <= '0;
			res_q.inside_box   <= 1'b0;
			unique case (req.cmd)
				CMD_ADD: begin
					if (full) begin
						res_q.status <= STATUS_FULL;
					end else begin
						res_q.status       <= STATUS_OK;
						res_q.result_index <= RIDX_W'(count_q);
					end
				end
				CMD_REMOVE: res_q.status <= index_ok ? STATUS_OK : STATUS_BAD_INDEX;
				CMD_QUERY:  res_q.status <= (count_q != '0) ? STATUS_OK : STATUS_EMPTY;
				default:    res_q.status <= STATUS_OK;
			endcase
		end else if (query_done) begin
			res_q.status <= STATUS_OK;
			if (found_q) begin
				res_q.result_index <= RIDX_W'(idx_in_q);
				res_q.inside_box   <= 1'b1;
			end else begin
				res_q.result_index <= RIDX_W'(idx_all_q);
				res_q.inside_box   <= 1'b0;
			end
		end

		if ((state_q == ST_RESP) && out_free) begin
			resp_q <= res_q;
		end
	end

	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;

endmodule

// ===== sim/reflection_probe_selector_unit_tb.sv =====
// ----------------------------------------------------------------------------
// reflection_probe_selector_unit_tb
// self-checking bench for the probe table: add, remove and point query
// requests go in through a valid / stall driver and every response is
// compared against a behavioural copy of the table kept in this bench; a
// directed opening covers the corner cases, random traffic follows under
// three sender / receiver back-pressure mixes
// ----------------------------------------------------------------------------
module reflection_probe_selector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rps_pkg::*;

	localparam int unsigned TABLE_DEPTH = MAX_PROBES_DEF;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_CYCLES = 30;
	localparam int          PRINT_CAP = 40;

	typedef logic signed [COORD_W-1:0] coord_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	rps_req_t  req = '0;
	logic      resp_valid;
	logic      resp_stall = 1'b0;
	rps_resp_t resp;

	reflection_probe_selector_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.resp_valid (resp_valid),
		.resp_stall (resp_stall),
		.resp       (resp)
	);

	// requests waiting for the driver and responses waiting for the dut
	rps_req_t    pending_req [$];
	rps_resp_t   expected_resp [$];

	// behavioural copy of the probe table, updated on every accepted request
	rps_entry_t  probe_table [TABLE_DEPTH];
	int unsigned probe_total = 0;

	// occupancy as the generator sees it, so random traffic can aim at full
	// and empty tables
	int unsigned shadow_total = 0;
	coord_t      last_cx = '0, last_cy = '0, last_cz = '0;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          req_taken = 1'b0;
	int          error_count = 0;
	int          cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_CAP)
			$display("%0t ns mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// expected response for one request, with the table update it causes
	function automatic rps_resp_t predict_response(input rps_req_t r);
		rps_resp_t  res;
		rps_entry_t e;
		int         k, dx, dy, dz;
		longint     sq_dist, best_any, best_in;
		bit         found_in, hit;
		int         pick_any, pick_in;
		res = '0;
		best_any = 0;
		best_in = 0;
		found_in = 1'b0;
		pick_any = 0;
		pick_in = 0;
		case (r.cmd)
			CMD_ADD: begin
				if (probe_total >= TABLE_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					probe_table[probe_total] = '{cx: r.pos_x, cy: r.pos_y, cz: r.pos_z,
						lo_x: r.box_lo_x, lo_y: r.box_lo_y, lo_z: r.box_lo_z,
						hi_x: r.box_hi_x, hi_y: r.box_hi_y, hi_z: r.box_hi_z};
					res.result_index = probe_total[RIDX_W-1:0];
					probe_total++;
				end
			end
			CMD_REMOVE: begin
				if (r.entry_index >= probe_total) begin
					res.status = STATUS_BAD_INDEX;
				end else begin
					// later entries close the gap, order is kept
					for (k = r.entry_index; k + 1 < probe_total; k++)
						probe_table[k] = probe_table[k + 1];
					probe_total--;
				end
			end
			CMD_QUERY: begin
				if (probe_total == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					for (k = 0; k < probe_total; k++) begin
						e = probe_table[k];
						dx = $signed(r.pos_x) - $signed(e.cx);
						dy = $signed(r.pos_y) - $signed(e.cy);
						dz = $signed(r.pos_z) - $signed(e.cz);
						sq_dist = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
						// box bounds are inclusive; an inverted box holds nothing
						hit = dx >= $signed(e.lo_x) && dx <= $signed(e.hi_x) &&
							dy >= $signed(e.lo_y) && dy <= $signed(e.hi_y) &&
							dz >= $signed(e.lo_z) && dz <= $signed(e.hi_z);
						// strict compares so that ties stay with the earliest entry
						if (k == 0 || sq_dist < best_any) begin
							best_any = sq_dist;
							pick_any = k;
						end
						if (hit && (!found_in || sq_dist < best_in)) begin
							found_in = 1'b1;
							best_in = sq_dist;
							pick_in = k;
						end
					end
					res.result_index = found_in ? pick_in[RIDX_W-1:0] : pick_any[RIDX_W-1:0];
					res.inside_box = found_in;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// request of the given command with random bits in every field it ignores
	function automatic rps_req_t noise_request(input rps_cmd_t c);
		logic [159:0] raw;
		rps_req_t     r;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		r = raw[$bits(rps_req_t)-1:0];
		r.cmd = c;
		return r;
	endfunction

	function automatic rps_req_t add_request(input coord_t x, y, z,
			input coord_t lx, ly, lz, input coord_t hx, hy, hz);
		rps_req_t r;
		r = noise_request(CMD_ADD);
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.box_lo_x = lx;
		r.box_lo_y = ly;
		r.box_lo_z = lz;
		r.box_hi_x = hx;
		r.box_hi_y = hy;
		r.box_hi_z = hz;
		return r;
	endfunction

	function automatic rps_req_t query_request(input coord_t x, y, z);
		rps_req_t r;
		r = noise_request(CMD_QUERY);
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		return r;
	endfunction

	function automatic rps_req_t remove_request(input int idx);
		rps_req_t r;
		r = noise_request(CMD_REMOVE);
		r.entry_index = idx[EIDX_W-1:0];
		return r;
	endfunction

	// queues a request and tracks how it changes the table occupancy
	task automatic push_request(input rps_req_t r);
		pending_req = {pending_req, r};
		if (r.cmd == CMD_ADD && shadow_total < TABLE_DEPTH)
			shadow_total++;
		else if (r.cmd == CMD_REMOVE && r.entry_index < shadow_total)
			shadow_total--;
	endtask

	// mostly a small cluster around the origin so boxes overlap, sometimes
	// the full range and the two extremes
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			6:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			7, 8:    return coord_t'($urandom());
			default: return coord_t'($urandom_range(0, 1023) - 512);
		endcase
	endfunction

	task automatic pick_bounds(output coord_t lo, output coord_t hi);
		case ($urandom_range(0, 9))
			0: begin
				// inverted on this axis
				lo = coord_t'($urandom_range(1, 400));
				hi = coord_t'(0 - $urandom_range(0, 400));
			end
			1: begin
				lo = coord_t'($urandom());
				hi = coord_t'($urandom());
			end
			default: begin
				lo = coord_t'(0 - $urandom_range(0, 700));
				hi = coord_t'($urandom_range(0, 700));
			end
		endcase
	endtask

	task automatic queue_directed();
		// empty table: query, remove and the unused command
		push_request(query_request(0, 0, 0));
		push_request(remove_request(0));
		push_request(rps_req_t'('1));
		push_request(noise_request(CMD_NOP));
		// small box at the origin, full-range box at the top corner,
		// inverted box at the bottom corner, then a huge box tying the first
		push_request(add_request(0, 0, 0, -5, -5, -5, 5, 5, 5));
		push_request(add_request(16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		push_request(add_request(16'sh8000, 16'sh8000, 16'sh8000, 1, 1, 1, -1, -1, -1));
		push_request(add_request(0, 0, 0,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff));
		// on the inclusive edge of the small box, tie goes to the earlier entry
		push_request(query_request(5, -5, 5));
		push_request(query_request(6, 0, 0));
		push_request(query_request(16'sh7fff, 16'sh7fff, 16'sh7fff));
		push_request(query_request(16'sh8000, 16'sh8000, 16'sh8000));
		// drop the huge box so the bottom corner falls back to nearest centre
		push_request(remove_request(3));
		push_request(query_request(16'sh8000, 16'sh8000, 16'sh8000));
		push_request(query_request(6, 0, 0));
		// index at the count and at the top of the range
		push_request(remove_request(3));
		push_request(remove_request(15));
		push_request(remove_request(0));
		push_request(query_request(0, 0, 0));
		push_request(remove_request(1));
		push_request(remove_request(0));
		push_request(query_request(16'sh7fff, 16'sh8000, 0));
	endtask

	// random traffic in runs that fill, drain or mix the table
	task automatic queue_random(input int n);
		int       mode, left, pick, add_w, qry_w, rem_w, idx;
		coord_t   px, py, pz, lx, ly, lz, hx, hy, hz;
		left = 0;
		mode = 0;
		repeat (n) begin
			if (left == 0) begin
				mode = $urandom_range(0, 4);
				left = $urandom_range(15, 40);
			end
			left--;
			case (mode)
				0, 1: begin add_w = 75; qry_w = 20; rem_w = 3; end
				2:    begin add_w = 7;  qry_w = 30; rem_w = 60; end
				default: begin add_w = 25; qry_w = 50; rem_w = 20; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < add_w) begin
				if ($urandom_range(0, 9) == 0) begin
					// same centre as the last probe, to force distance ties
					px = last_cx;
					py = last_cy;
					pz = last_cz;
				end else begin
					px = rand_coord();
					py = rand_coord();
					pz = rand_coord();
				end
				pick_bounds(lx, hx);
				pick_bounds(ly, hy);
				pick_bounds(lz, hz);
				last_cx = px;
				last_cy = py;
				last_cz = pz;
				push_request(add_request(px, py, pz, lx, ly, lz, hx, hy, hz));
			end else if (pick < add_w + qry_w) begin
				if ($urandom_range(0, 6) == 0)
					push_request(query_request(last_cx, last_cy, last_cz));
				else
					push_request(query_request(rand_coord(), rand_coord(), rand_coord()));
			end else if (pick < add_w + qry_w + rem_w) begin
				if (shadow_total != 0 && $urandom_range(0, 4) != 0)
					idx = $urandom_range(0, shadow_total - 1);
				else
					idx = $urandom_range(0, 15);
				push_request(remove_request(idx));
			end else begin
				push_request(noise_request(CMD_NOP));
			end
		end
	endtask

	// waits until every queued request has been answered
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || req_valid || expected_resp.size() != 0);
	endtask

	// request driver: a presented request holds until taken, gaps only
	// between requests
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			resp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// response check first, then prediction of the request taken at this edge
	always @(posedge clk) begin : monitor
		rps_resp_t want;
		if (arst_n) begin
			if (resp_valid && !resp_stall) begin
				if (expected_resp.size() == 0) begin
					report_mismatch($sformatf("response with none outstanding: %p", resp));
				end else begin
					want = expected_resp.pop_front();
					if (resp.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							resp.status, want.status));
					if (resp.result_index !== want.result_index)
						report_mismatch($sformatf("result_index got %0d want %0d",
							resp.result_index, want.result_index));
					if (resp.inside_box !== want.inside_box)
						report_mismatch($sformatf("inside_box got %0b want %0b",
							resp.inside_box, want.inside_box));
				end
			end
			req_taken = req_valid && !req_stall;
			if (req_taken)
				expected_resp = {expected_resp, predict_response(req)};
		end else begin
			req_taken = 1'b0;
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("reflection_probe_selector_unit test failed");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 23;
		recv_idle_pct = 51;
		queue_directed();
		queue_random(270);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// sender now the slow side
		send_idle_pct = 51;
		recv_idle_pct = 23;
		queue_random(270);
		wait_drained();

		// back to back, no idling either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(270);
		wait_drained();

		// catch any stray response after the last one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("reflection_probe_selector_unit test passed");
		else
			$display("reflection_probe_selector_unit test failed");
		$finish;
	end

endmodule
